[src/hsn_pkg.sv]
// hsn_pkg: shared types and constants for the heightmap normal unit.
// No dependencies.
`timescale 1ns / 1ps
package hsn_pkg;
  localparam int MaxCols = 256;
  localparam int MaxRows = 256;
  localparam int ColW = 8;
  localparam int RowW = 8;
  localparam int AddrW = ColW + RowW;

  localparam logic [1:0] RegGridWidth = 2'd0;
  localparam logic [1:0] RegGridHeight = 2'd1;
  localparam logic [1:0] RegSmoothing = 2'd2;

  localparam logic FuncWrite = 1'b0;
  localparam logic FuncRead = 1'b1;

  // signed height difference range fits 9 bits, n = p*p + q*q + 1 fits 18 bits
  typedef logic signed [9:0] diff_t;
  typedef logic [17:0] norm_sq_t;
  typedef logic [22:0] root_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FETCH,
    ST_FETCH_WAIT,
    ST_FACET,
    ST_ROOT,
    ST_SCALE,
    ST_NEXT_CELL,
    ST_SELECT,
    ST_FINISH,
    ST_OUT
  } state_t;

  // request from sequencer to the inverse root unit
  typedef struct packed {
    logic     start;
    norm_sq_t n;
  } root_req_t;

  typedef struct packed {
    logic  done;
    root_t r;
  } root_rsp_t;
endpackage

[src/hsn_inv_root.sv]
// hsn_inv_root: bit-serial inverse square root, r = largest with r*r*n <= 2^44.
// Depends on hsn_pkg. Each result bit squares the trial, then multiplies by n.
`timescale 1ns / 1ps
module hsn_inv_root (
  input  logic               clk,
  input  logic               rst,
  input  hsn_pkg::root_req_t req,
  output hsn_pkg::root_rsp_t rsp
);
  logic              busy;
  logic              phase;
  logic [4:0]        bit_idx;
  hsn_pkg::root_t    r;
  hsn_pkg::norm_sq_t n;
  logic [45:0]       sq;
  logic              done;

  logic [22:0] trial;
  logic [63:0] prod;

  assign trial = r | (23'd1 << bit_idx);
  // a product of at most 46 x 18 bits is split over two phases: square first
  assign prod = {18'd0, sq} * {46'd0, n};

  // step sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      phase <= 1'b0;
      bit_idx <= 5'd0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        phase <= 1'b0;
        bit_idx <= 5'd22;
        r <= '0;
        n <= req.n;
      end else if (busy) begin
        if (!phase) begin
          sq <= 46'(trial) * 46'(trial);
          phase <= 1'b1;
        end else begin
          phase <= 1'b0;
          if (prod <= 64'h1000_0000_0000) r <= trial;
          if (bit_idx == 5'd0) begin
            busy <= 1'b0;
            done <= 1'b1;
          end else begin
            bit_idx <= bit_idx - 5'd1;
          end
        end
      end
    end
  end

  assign rsp.done = done;
  assign rsp.r = r;
endmodule

[src/heightmap_smoothed_normals.sv]
// heightmap_smoothed_normals: top level, height store, fetch/facet sequencer.
// Depends on hsn_pkg and hsn_inv_root.
// Writes can follow back to back. A read inside the grid walks the cell and its
// in-grid neighbors: five height fetches, a step per facet slot, the shared inverse
// root per existing facet, a fold and a neighbor select per cell, then rounding.
// A read outside the grid goes straight to the result. One item at a time; the
// result waits for out_ready.
// rst clears control state and restores grid 256x256, weight 77; the store is not cleared.
`timescale 1ns / 1ps
module heightmap_smoothed_normals (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        func,
  input  logic [7:0]  col,
  input  logic [7:0]  row,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  output logic        out_valid,
  input  logic        out_ready,
  output logic signed [15:0] normal_x,
  output logic signed [15:0] normal_y,
  output logic signed [15:0] normal_z,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data
);
  // configuration
  logic [8:0] grid_width, grid_height;
  logic [7:0] smoothing_weight;
  always_ff @(posedge clk) begin
    if (rst) begin
      grid_width <= 9'd256;
      grid_height <= 9'd256;
      smoothing_weight <= 8'd77;
    end else if (cfg_we) begin
      unique case (cfg_index)
        hsn_pkg::RegGridWidth:  grid_width <= cfg_data;
        hsn_pkg::RegGridHeight: grid_height <= cfg_data;
        hsn_pkg::RegSmoothing:  smoothing_weight <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  logic [8:0] w, h;
  always_comb begin
    w = (grid_width < 9'd2) ? 9'd2 : (grid_width > 9'd256 ? 9'd256 : grid_width);
    h = (grid_height < 9'd2) ? 9'd2 : (grid_height > 9'd256 ? 9'd256 : grid_height);
  end

  hsn_pkg::state_t state, state_next;

  // latched item
  logic [7:0] x0, z0;
  // cell being processed: 0 own, 1 left, 2 right, 3 up, 4 down, 5 all done
  logic [2:0] cell_idx;
  logic [7:0] cx, cz;
  // fetch index: 0 center, 1 up, 2 down, 3 left, 4 right
  logic [2:0] fidx;
  logic [7:0] hv [5];
  logic [1:0] facet;
  logic signed [9:0] fp, fq;
  logic signed [19:0] acc [3];
  logic signed [22:0] nb [3];
  logic signed [19:0] own [3];
  logic signed [15:0] res [3];

  // store: one write and one read per cycle, registered read
  logic [7:0] mem [hsn_pkg::MaxCols * hsn_pkg::MaxRows];
  logic [15:0] rd_addr;
  logic [7:0] rd_data;
  logic        wr_en;
  logic [9:0]  rgb_sum;
  logic [19:0] rgb_third;
  assign rgb_sum = 10'(red) + 10'(green) + 10'(blue);
  // sum / 3 as sum * 683 / 2048, exact for sums up to 765
  assign rgb_third = (20'(rgb_sum) * 20'd683) >> 11;
  assign wr_en = in_valid && in_ready && (func == hsn_pkg::FuncWrite);
  always_ff @(posedge clk) begin
    if (wr_en) mem[{row, col}] <= rgb_third[7:0];
    rd_data <= mem[rd_addr];
  end

  // neighbor flags of current cell
  logic up, dn, lf, rt;
  assign up = cz != 8'd0;
  assign dn = (9'(cz) + 9'd1) < h;
  assign lf = cx != 8'd0;
  assign rt = (9'(cx) + 9'd1) < w;

  always_comb begin
    rd_addr = {cz, cx};
    unique case (fidx)
      3'd1: rd_addr = {cz - 8'd1, cx};
      3'd2: rd_addr = {cz + 8'd1, cx};
      3'd3: rd_addr = {cz, cx - 8'd1};
      3'd4: rd_addr = {cz, cx + 8'd1};
      default: ;
    endcase
  end

  // differences a (up), c (down), b (left), d (right)
  logic signed [9:0] da, dc, db, dd;
  assign da = up ? 10'(signed'({2'b0, hv[1]}) - signed'({2'b0, hv[0]})) : '0;
  assign dc = dn ? 10'(signed'({2'b0, hv[2]}) - signed'({2'b0, hv[0]})) : '0;
  assign db = lf ? 10'(signed'({2'b0, hv[3]}) - signed'({2'b0, hv[0]})) : '0;
  assign dd = rt ? 10'(signed'({2'b0, hv[4]}) - signed'({2'b0, hv[0]})) : '0;

  logic facet_ok;
  logic signed [9:0] sel_p, sel_q;
  always_comb begin
    unique case (facet)
      2'd0: begin facet_ok = lf && up; sel_p = db; sel_q = da; end
      2'd1: begin facet_ok = lf && dn; sel_p = db; sel_q = -dc; end
      2'd2: begin facet_ok = rt && dn; sel_p = -dd; sel_q = -dc; end
      default: begin facet_ok = rt && up; sel_p = -dd; sel_q = da; end
    endcase
  end

  // squared length of the facet being started
  hsn_pkg::root_req_t rreq;
  hsn_pkg::root_rsp_t rrsp;
  logic signed [19:0] sq_p, sq_q;
  assign sq_p = 20'(sel_p) * 20'(sel_p);
  assign sq_q = 20'(sel_q) * 20'(sel_q);
  assign rreq.start = (state == hsn_pkg::ST_FACET) && facet_ok;
  assign rreq.n = 18'(sq_p + sq_q + 20'sd1);
  hsn_inv_root u_root (.clk(clk), .rst(rst), .req(rreq), .rsp(rrsp));

  // scale step: one component per cycle through one multiplier
  logic [1:0] comp;
  logic signed [9:0] cval;
  logic [8:0] cmag;
  logic [31:0] cprod;
  logic signed [15:0] unitv;
  always_comb begin
    unique case (comp)
      2'd0: cval = fp;
      2'd2: cval = fq;
      default: cval = 10'sd1;
    endcase
    cmag = cval[9] ? 9'(-cval) : 9'(cval);
    cprod = 32'(cmag) * 32'(rrsp.r);
    unitv = cval[9] ? -16'((cprod + 32'd128) >> 8) : 16'((cprod + 32'd128) >> 8);
  end

  // neighbor cell coordinates
  logic n_ok;
  logic [7:0] nx, nz;
  always_comb begin
    nx = x0; nz = z0; n_ok = 1'b1;
    unique case (cell_idx)
      3'd1: begin nx = x0 - 8'd1; n_ok = x0 != 8'd0; end
      3'd2: begin nx = x0 + 8'd1; n_ok = (9'(x0) + 9'd1) < w; end
      3'd3: begin nz = z0 - 8'd1; n_ok = z0 != 8'd0; end
      3'd4: begin nz = z0 + 8'd1; n_ok = (9'(z0) + 9'd1) < h; end
      default: ;
    endcase
  end

  // finish: one component per cycle
  logic signed [39:0] tot;
  logic signed [39:0] u;
  logic signed [39:0] qv;
  logic signed [15:0] qs;
  always_comb begin
    tot = (40'(own[comp]) <<< 8) + 40'(nb[comp]) * signed'({32'd0, smoothing_weight});
    u = tot + 40'sd512;
    qv = u >>> 10;
    if (qv > 40'sd32767) qs = 16'sd32767;
    else if (qv < -40'sd32768) qs = -16'sd32768;
    else qs = 16'(qv);
  end

  logic done_cells;
  assign done_cells = cell_idx == 3'd5;

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      hsn_pkg::ST_IDLE:
        if (in_valid && func == hsn_pkg::FuncRead) begin
          if (9'(col) < w && 9'(row) < h) state_next = hsn_pkg::ST_FETCH;
          else state_next = hsn_pkg::ST_OUT;
        end
      hsn_pkg::ST_FETCH: state_next = hsn_pkg::ST_FETCH_WAIT;
      hsn_pkg::ST_FETCH_WAIT:
        state_next = (fidx == 3'd4) ? hsn_pkg::ST_FACET : hsn_pkg::ST_FETCH;
      hsn_pkg::ST_FACET:
        if (facet_ok) state_next = hsn_pkg::ST_ROOT;
        else if (facet == 2'd3) state_next = hsn_pkg::ST_NEXT_CELL;
      hsn_pkg::ST_ROOT: if (rrsp.done) state_next = hsn_pkg::ST_SCALE;
      hsn_pkg::ST_SCALE:
        if (comp == 2'd2)
          state_next = (facet == 2'd3) ? hsn_pkg::ST_NEXT_CELL : hsn_pkg::ST_FACET;
      hsn_pkg::ST_NEXT_CELL: state_next = hsn_pkg::ST_SELECT;
      hsn_pkg::ST_SELECT:
        if (done_cells) state_next = hsn_pkg::ST_FINISH;
        else if (n_ok) state_next = hsn_pkg::ST_FETCH;
      hsn_pkg::ST_FINISH: if (comp == 2'd2) state_next = hsn_pkg::ST_OUT;
      hsn_pkg::ST_OUT: if (out_ready) state_next = hsn_pkg::ST_IDLE;
      default: state_next = hsn_pkg::ST_IDLE;
    endcase
  end

  // handshake outputs
  always_comb begin
    in_ready = state == hsn_pkg::ST_IDLE;
    out_valid = state == hsn_pkg::ST_OUT;
  end

  assign normal_x = res[0];
  assign normal_y = res[1];
  assign normal_z = res[2];

  always_ff @(posedge clk) begin
    if (rst) state <= hsn_pkg::ST_IDLE;
    else state <= state_next;
  end

  // datapath registers
  always_ff @(posedge clk) begin
    unique case (state)
      hsn_pkg::ST_IDLE: begin
        x0 <= col; z0 <= row; cx <= col; cz <= row;
        cell_idx <= 3'd0; fidx <= 3'd0; facet <= 2'd0; comp <= 2'd0;
        for (int i = 0; i < 3; i++) begin
          acc[i] <= '0; nb[i] <= '0;
        end
        res[0] <= 16'sd0; res[1] <= 16'sd4096; res[2] <= 16'sd0;
      end
      hsn_pkg::ST_FETCH: ;
      hsn_pkg::ST_FETCH_WAIT: begin
        hv[fidx] <= rd_data;
        fidx <= fidx + 3'd1;
      end
      hsn_pkg::ST_FACET: begin
        fp <= sel_p; fq <= sel_q;
        comp <= 2'd0;
        if (!facet_ok) facet <= facet + 2'd1;
      end
      hsn_pkg::ST_ROOT: ;
      hsn_pkg::ST_SCALE: begin
        acc[comp] <= acc[comp] + 20'(unitv);
        comp <= comp + 2'd1;
        if (comp == 2'd2) facet <= facet + 2'd1;
      end
      hsn_pkg::ST_NEXT_CELL: begin
        // fold the finished cell into its sum
        for (int i = 0; i < 3; i++) begin
          if (cell_idx == 3'd0) own[i] <= acc[i];
          else nb[i] <= nb[i] + 23'(acc[i]);
          acc[i] <= '0;
        end
        cell_idx <= cell_idx + 3'd1;
      end
      hsn_pkg::ST_SELECT: begin
        // enter the next in-grid neighbor, skip the others
        fidx <= 3'd0; facet <= 2'd0; comp <= 2'd0;
        if (!done_cells) begin
          if (n_ok) begin
            cx <= nx; cz <= nz;
          end else begin
            cell_idx <= cell_idx + 3'd1;
          end
        end
      end
      hsn_pkg::ST_FINISH: begin
        res[comp] <= qs;
        comp <= comp + 2'd1;
        if (comp == 2'd2 && res[0] == 16'sd0 && qs == 16'sd0 && res[1] == 16'sd0)
          res[1] <= 16'sd4096;
      end
      hsn_pkg::ST_OUT: ;
      default: ;
    endcase
  end
endmodule

[verif/hsn_normal_checker.sv]
// hsn_normal_checker: watches the item and result channels of the heightmap
// normal unit, keeps a shadow height store, predicts each normal and compares.
// Depends on hsn_pkg.
`timescale 1ns / 1ps
module hsn_normal_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  input  logic        in_ready,
  input  logic        func,
  input  logic [7:0]  col,
  input  logic [7:0]  row,
  input  logic [7:0]  red,
  input  logic [7:0]  green,
  input  logic [7:0]  blue,
  input  logic        out_valid,
  input  logic        out_ready,
  input  logic signed [15:0] normal_x,
  input  logic signed [15:0] normal_y,
  input  logic signed [15:0] normal_z,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [8:0]  cfg_data,
  output int          fail_count,
  output int          pending_count
);

  typedef struct {
    logic signed [15:0] nx;
    logic signed [15:0] ny;
    logic signed [15:0] nz;
  } normal_t;

  logic [7:0]  shadow_height [hsn_pkg::MaxCols*hsn_pkg::MaxRows];
  logic [8:0]  width_reg;
  logic [8:0]  height_reg;
  logic [7:0]  weight_reg;
  normal_t     normal_queue[$];

  function automatic int unsigned clamp_dim(logic [8:0] v, int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  function automatic int height_at(int unsigned x, int unsigned z);
    return int'(shadow_height[z*hsn_pkg::MaxCols + x]);
  endfunction

  // largest r with r*r*n <= 2^44, bit by bit
  function automatic longint unsigned inv_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 22; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t * n <= (64'd1 << 44)) r = t;
    end
    return r;
  endfunction

  function automatic int unit_comp(int c, longint unsigned r);
    longint unsigned mag;
    int v;
    mag = (c < 0) ? -c : c;
    v = int'((mag * r + 128) >> 8);
    return (c < 0) ? -v : v;
  endfunction

  function automatic void add_facet(int p, int q, inout int ax, inout int ay, inout int az);
    longint unsigned r;
    r = inv_root(longint'(p*p + q*q + 1));
    ax += unit_comp(p, r);
    ay += int'((r + 128) >> 8);
    az += unit_comp(q, r);
  endfunction

  function automatic void facet_sum(int unsigned x, int unsigned z, int unsigned w,
                                    int unsigned h, output int ax, output int ay,
                                    output int az);
    int h0, a, b, c, d;
    bit up, dn, lf, rt;
    h0 = height_at(x, z);
    a = 0; b = 0; c = 0; d = 0;
    ax = 0; ay = 0; az = 0;
    up = z > 0;
    dn = z + 1 < h;
    lf = x > 0;
    rt = x + 1 < w;
    if (up) a = height_at(x, z - 1) - h0;
    if (dn) c = height_at(x, z + 1) - h0;
    if (lf) b = height_at(x - 1, z) - h0;
    if (rt) d = height_at(x + 1, z) - h0;
    if (lf && up) add_facet(b, a, ax, ay, az);
    if (lf && dn) add_facet(b, -c, ax, ay, az);
    if (rt && dn) add_facet(-d, -c, ax, ay, az);
    if (rt && up) add_facet(-d, a, ax, ay, az);
  endfunction

  // Q.22 to Q4.12, round half up, then saturate
  function automatic logic signed [15:0] to_q12(longint v);
    longint u, q;
    u = v + 512;
    if (u >= 0) q = u >>> 10;
    else q = -(((-u) + 1023) >>> 10);
    if (q > 32767) q = 32767;
    if (q < -32768) q = -32768;
    return q[15:0];
  endfunction

  function automatic normal_t smoothed_normal(int unsigned x, int unsigned z);
    normal_t res;
    int unsigned w, h;
    int own [3];
    int nb [3];
    int t [3];
    w = clamp_dim(width_reg, hsn_pkg::MaxCols);
    h = clamp_dim(height_reg, hsn_pkg::MaxRows);
    res.nx = 0; res.ny = 16'sd4096; res.nz = 0;
    if (x >= w || z >= h) return res;
    nb = '{0, 0, 0};
    facet_sum(x, z, w, h, own[0], own[1], own[2]);
    if (x > 0) begin
      facet_sum(x - 1, z, w, h, t[0], t[1], t[2]);
      foreach (nb[i]) nb[i] += t[i];
    end
    if (x + 1 < w) begin
      facet_sum(x + 1, z, w, h, t[0], t[1], t[2]);
      foreach (nb[i]) nb[i] += t[i];
    end
    if (z > 0) begin
      facet_sum(x, z - 1, w, h, t[0], t[1], t[2]);
      foreach (nb[i]) nb[i] += t[i];
    end
    if (z + 1 < h) begin
      facet_sum(x, z + 1, w, h, t[0], t[1], t[2]);
      foreach (nb[i]) nb[i] += t[i];
    end
    res.nx = to_q12(longint'(own[0]) * 256 + longint'(weight_reg) * nb[0]);
    res.ny = to_q12(longint'(own[1]) * 256 + longint'(weight_reg) * nb[1]);
    res.nz = to_q12(longint'(own[2]) * 256 + longint'(weight_reg) * nb[2]);
    // zero normal falls back to straight up
    if (res.nx == 0 && res.ny == 0 && res.nz == 0) res.ny = 16'sd4096;
    return res;
  endfunction

  task automatic report(string what, int got, int want);
    $display("[%0t] MISMATCH %s: got %0d, want %0d", $realtime, what, got, want);
    fail_count++;
  endtask

  initial begin
    fail_count = 0;
    pending_count = 0;
    width_reg = 9'd256;
    height_reg = 9'd256;
    weight_reg = 8'd77;
  end

  always @(posedge clk) begin
    if (rst) begin
      width_reg <= 9'd256;
      height_reg <= 9'd256;
      weight_reg <= 8'd77;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          hsn_pkg::RegGridWidth: width_reg <= cfg_data;
          hsn_pkg::RegGridHeight: height_reg <= cfg_data;
          hsn_pkg::RegSmoothing: weight_reg <= cfg_data[7:0];
          default: ;
        endcase
      end
      // result transfer: compare against oldest prediction first
      if (out_valid && out_ready) begin
        if (normal_queue.size() == 0) begin
          report("unexpected result", normal_x, 0);
        end else begin
          normal_t want;
          want = normal_queue.pop_front();
          if (normal_x !== want.nx) report("normal_x", normal_x, want.nx);
          if (normal_y !== want.ny) report("normal_y", normal_y, want.ny);
          if (normal_z !== want.nz) report("normal_z", normal_z, want.nz);
        end
      end
      // item transfer
      if (in_valid && in_ready) begin
        if (func == hsn_pkg::FuncRead) begin
          normal_queue.push_back(smoothed_normal(col, row));
        end else begin
          shadow_height[int'(row)*hsn_pkg::MaxCols + int'(col)] =
            8'((int'(red) + int'(green) + int'(blue)) / 3);
        end
      end
    end
    pending_count = normal_queue.size();
  end

endmodule

[verif/tb_heightmap_smoothed_normals.sv]
// tb_heightmap_smoothed_normals: stimulus and verdict for the heightmap normal unit.
// Depends on hsn_pkg, heightmap_smoothed_normals and hsn_normal_checker.
`timescale 1ns / 1ps
module tb_heightmap_smoothed_normals;

  localparam int CycleLimit = 4000000;
  localparam int PhaseItems = 85;
  localparam int NumPhases = 8;

  logic clk = 1'b0;
  logic rst;
  logic in_valid, in_ready, func;
  logic [7:0] col, row, red, green, blue;
  logic out_valid, out_ready;
  logic signed [15:0] normal_x, normal_y, normal_z;
  logic cfg_we;
  logic [1:0] cfg_index;
  logic [8:0] cfg_data;
  int fail_count, pending_count;

  int cycle_count = 0;
  int burst_left = 0;
  int item_count = 0;
  int unsigned grid_w = 256;
  int unsigned grid_h = 256;
  bit written [hsn_pkg::MaxCols*hsn_pkg::MaxRows];

  // phase settings, out-of-range sizes included to hit the clamp
  int phase_w [NumPhases] = '{2, 0, 5, 511, 16, 7, 1, 256};
  int phase_h [NumPhases] = '{2, 1, 3, 300, 16, 12, 9, 256};
  int phase_wt [NumPhases] = '{0, 255, 128, 77, 255, 1, 200, 0};

  always #5 clk = ~clk;

  heightmap_smoothed_normals dut (.*);

  hsn_normal_checker u_checker (.*);

  // cycle watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CycleLimit) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // receiver stall pattern: mode follows bits 10:9 of the cycle count
  always @(posedge clk) begin
    case (cycle_count[10:9])
      2'd0: out_ready <= 1'b1;
      2'd1: out_ready <= ($urandom_range(0, 1) == 0);
      2'd2: out_ready <= ($urandom_range(0, 3) == 0);
      default: out_ready <= (cycle_count[4:0] > 5'd6);
    endcase
  end

  function automatic int unsigned clamp_dim(int v, int unsigned top);
    if (v < 2) return 2;
    if (v > top) return top;
    return v;
  endfunction

  // one transfer on the item channel, with burst/gap idling
  task automatic send(logic f, int unsigned x, int unsigned z,
                      logic [7:0] r, logic [7:0] g, logic [7:0] b);
    if (burst_left == 0) begin
      int gap;
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 20);
      if (gap > 0) begin
        in_valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 12);
    end
    burst_left--;
    in_valid <= 1'b1;
    func <= f;
    col <= x[7:0];
    row <= z[7:0];
    red <= r;
    green <= g;
    blue <= b;
    do @(posedge clk); while (!in_ready);
    if (f == hsn_pkg::FuncWrite) written[z*hsn_pkg::MaxCols + x] = 1'b1;
    item_count++;
  endtask

  task automatic write_cell(int unsigned x, int unsigned z);
    send(hsn_pkg::FuncWrite, x, z, $urandom_range(0, 255), $urandom_range(0, 255),
         $urandom_range(0, 255));
  endtask

  // a read touches every in-grid cell within two steps; write the missing ones
  task automatic read_cell(int unsigned x, int unsigned z);
    if (x < grid_w && z < grid_h) begin
      for (int dz = -2; dz <= 2; dz++) begin
        for (int dx = -2; dx <= 2; dx++) begin
          int cx, cz;
          cx = int'(x) + dx;
          cz = int'(z) + dz;
          if ((dx < 0 ? -dx : dx) + (dz < 0 ? -dz : dz) <= 2 && cx >= 0 && cz >= 0 &&
              cx < int'(grid_w) && cz < int'(grid_h) &&
              !written[cz*hsn_pkg::MaxCols + cx])
            write_cell(cx, cz);
        end
      end
    end
    send(hsn_pkg::FuncRead, x, z, $urandom_range(0, 255), $urandom_range(0, 255),
         $urandom_range(0, 255));
  endtask

  // wait until every prediction is matched, then wait further with the item channel idle
  task automatic drain();
    in_valid <= 1'b0;
    burst_left = 0;
    @(posedge clk);
    while (pending_count != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  // holds the write enable high; the caller drops it after the last write
  task automatic write_reg(logic [1:0] idx, int value);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value[8:0];
    @(posedge clk);
  endtask

  task automatic set_grid(int w, int h, int wt);
    drain();
    write_reg(hsn_pkg::RegGridWidth, w);
    write_reg(hsn_pkg::RegGridHeight, h);
    write_reg(hsn_pkg::RegSmoothing, wt);
    cfg_we <= 1'b0;
    @(posedge clk);
    grid_w = clamp_dim(w, hsn_pkg::MaxCols);
    grid_h = clamp_dim(h, hsn_pkg::MaxRows);
  endtask

  initial begin
    int target;
    rst <= 1'b1;
    in_valid <= 1'b0;
    func <= hsn_pkg::FuncWrite;
    col <= '0;
    row <= '0;
    red <= '0;
    green <= '0;
    blue <= '0;
    cfg_we <= 1'b0;
    cfg_index <= '0;
    cfg_data <= '0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: reset settings, extreme colors and corners
    send(hsn_pkg::FuncWrite, 0, 0, 8'd0, 8'd0, 8'd0);
    send(hsn_pkg::FuncWrite, 255, 255, 8'd255, 8'd255, 8'd255);
    read_cell(0, 0);
    read_cell(255, 255);
    read_cell(128, 7);

    // smallest grid, no smoothing, read outside the grid
    set_grid(2, 2, 0);
    read_cell(1, 1);
    read_cell(255, 0);
    read_cell(0, 255);

    // flat area with full weight saturates
    set_grid(5, 3, 255);
    for (int z = 0; z < 3; z++)
      for (int x = 0; x < 5; x++)
        send(hsn_pkg::FuncWrite, x, z, 8'd90, 8'd91, 8'd92);
    read_cell(2, 1);

    // random phases
    for (int p = 0; p < NumPhases; p++) begin
      set_grid(phase_w[p], phase_h[p], phase_wt[p]);
      target = item_count + PhaseItems;
      while (item_count < target) begin
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 70)
          read_cell($urandom_range(0, grid_w - 1), $urandom_range(0, grid_h - 1));
        else if (pick < 80 && grid_w < hsn_pkg::MaxCols)
          read_cell($urandom_range(grid_w, 255), $urandom_range(0, 255));
        else if (pick < 85 && grid_h < hsn_pkg::MaxRows)
          read_cell($urandom_range(0, 255), $urandom_range(grid_h, 255));
        else
          write_cell($urandom_range(0, 255), $urandom_range(0, 255));
      end
    end

    drain();
    if (fail_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

[heightmap_smoothed_normals.f]
src/hsn_pkg.sv
src/hsn_inv_root.sv
src/heightmap_smoothed_normals.sv
verif/hsn_normal_checker.sv
verif/tb_heightmap_smoothed_normals.sv
